// ----- rtl/dqp_pkg.sv -----
`timescale 1ns / 1ps

package dqp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_LABEL,
    PH_TC,
    PH_TRAIL,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_NAME_LONG = 2'd3
  } status_t;

  localparam logic       KIND_CHAR    = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic       REG_MAX_LABEL = 1'b0;
  localparam logic       REG_MAX_NAME  = 1'b1;

  localparam logic [7:0] CH_DOT = 8'h2E;

  localparam logic [7:0] MAX_LABEL_RESET = 8'd63;
  localparam logic [8:0] MAX_NAME_RESET  = 9'd256;

  localparam int unsigned OUT_DATA_W = 56;

endpackage

// ----- rtl/dns_query_parser_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         tdata: msg_byte; tlast: msg_last
// m_axis    out        tuser: result_kind; tlast: name_end; tdata: see port
// cfg       in         cfg_index selects the register, cfg_data is the new value
//
// A beat is taken every cycle while the result register is empty or being
// drained. A result appears in the cycle after its byte. Besides the limits
// and the result, the state between bytes is the parser registers, updated
// in the same cycle as the byte. Reset returns the parser to the header and
// the limits to 63 and 256. A stalled result holds s_axis_tready low.

module dns_query_parser_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // msg_byte
  input  logic                            s_axis_tlast,  // msg_last
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // name_char[7:0], parse_status[9:8], query_type[25:10], query_class[41:26],
  // name_wire_bytes[50:42], extra_bytes_present[51], zero[55:52]
  output logic [dqp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,  // name_end
  output logic                            m_axis_tuser,  // result_kind
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [8:0]                      cfg_data
);
  import dqp_pkg::*;

  logic [7:0]  max_label;
  logic [8:0]  max_name;

  phase_t      phase, phase_next;
  logic [3:0]  pos_cnt, pos_cnt_next;
  logic        counts_ok, counts_ok_next;
  logic [7:0]  label_left, label_left_next;
  logic [8:0]  name_seen, name_seen_next;
  logic        first_len, first_len_next;
  logic [31:0] tc_bytes, tc_bytes_next;
  logic [1:0]  tc_cnt, tc_cnt_next;
  logic        name_err, name_err_next;

  logic        have_char;
  logic [7:0]  ch;
  logic        ch_end;
  logic [9:0]  name_sum;
  status_t     status;
  logic [OUT_DATA_W-1:0] result_data;
  logic        accept;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_last;
  logic                  out_user;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_user;

  assign name_sum = {1'b0, name_seen} + {2'b00, s_axis_tdata} + 10'd1;

  always_comb begin
    phase_next      = phase;
    pos_cnt_next    = (pos_cnt == 4'hF) ? pos_cnt : pos_cnt + 4'd1;
    counts_ok_next  = counts_ok;
    label_left_next = label_left;
    name_seen_next  = name_seen;
    first_len_next  = first_len;
    tc_bytes_next   = tc_bytes;
    tc_cnt_next     = tc_cnt;
    name_err_next   = name_err;
    have_char       = 1'b0;
    ch              = '0;
    ch_end          = 1'b0;
    status          = ST_OK;
    result_data     = '0;

    unique case (phase)
      PH_HEADER: begin
        if (pos_cnt == 4'd4 || (pos_cnt >= 4'd6 && pos_cnt <= 4'd9)) begin
          if (s_axis_tdata != 8'd0) counts_ok_next = 1'b0;
        end else if (pos_cnt == 4'd5) begin
          if (s_axis_tdata != 8'd1) counts_ok_next = 1'b0;
        end
        if (pos_cnt == 4'd11) begin
          phase_next = counts_ok_next ? PH_LENGTH : PH_STOP;
        end
      end
      PH_LENGTH: begin
        if (s_axis_tdata == 8'd0) begin
          have_char   = 1'b1;
          ch          = CH_DOT;
          ch_end      = 1'b1;
          phase_next  = PH_TC;
          tc_cnt_next = 2'd0;
        end else if (s_axis_tdata > max_label || name_sum >= {1'b0, max_name}) begin
          name_err_next = 1'b1;
          phase_next    = PH_STOP;
        end else begin
          if (!first_len) begin
            have_char = 1'b1;
            ch        = CH_DOT;
          end
          name_seen_next  = name_sum[8:0];
          label_left_next = s_axis_tdata;
          first_len_next  = 1'b0;
          phase_next      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        have_char       = 1'b1;
        ch              = s_axis_tdata;
        label_left_next = label_left - 8'd1;
        if (label_left_next == 8'd0) phase_next = PH_LENGTH;
      end
      PH_TC: begin
        tc_bytes_next = {tc_bytes[23:0], s_axis_tdata};
        tc_cnt_next   = tc_cnt + 2'd1;
        if (tc_cnt == 2'd3) phase_next = PH_TRAIL;
      end
      default: begin
      end
    endcase

    if (pos_cnt != 4'hF)         status = ST_TOO_SHORT;
    else if (!counts_ok_next)    status = ST_BAD_COUNT;
    else if (name_err_next)      status = ST_NAME_LONG;
    else if (phase_next != PH_TRAIL) status = ST_TOO_SHORT;
    else                         status = ST_OK;

    if (s_axis_tlast) begin
      result_data[9:8] = status;
      if (status == ST_OK) begin
        result_data[25:10] = tc_bytes_next[31:16];
        result_data[41:26] = tc_bytes_next[15:0];
        result_data[50:42] = name_seen_next + 9'd1;
        result_data[51]    = (phase == PH_TRAIL);
      end
      phase_next      = PH_HEADER;
      pos_cnt_next    = 4'd0;
      counts_ok_next  = 1'b1;
      label_left_next = 8'd0;
      name_seen_next  = 9'd0;
      first_len_next  = 1'b1;
      tc_bytes_next   = 32'd0;
      tc_cnt_next     = 2'd0;
      name_err_next   = 1'b0;
    end else begin
      result_data[7:0] = ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_label <= MAX_LABEL_RESET;
      max_name  <= MAX_NAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_LABEL: max_label <= cfg_data[7:0];
        REG_MAX_NAME:  max_name  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      pos_cnt    <= 4'd0;
      counts_ok  <= 1'b1;
      label_left <= 8'd0;
      name_seen  <= 9'd0;
      first_len  <= 1'b1;
      tc_bytes   <= 32'd0;
      tc_cnt     <= 2'd0;
      name_err   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      pos_cnt    <= pos_cnt_next;
      counts_ok  <= counts_ok_next;
      label_left <= label_left_next;
      name_seen  <= name_seen_next;
      first_len  <= first_len_next;
      tc_bytes   <= tc_bytes_next;
      tc_cnt     <= tc_cnt_next;
      name_err   <= name_err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (s_axis_tlast || have_char)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (s_axis_tlast || have_char)) begin
      out_data <= result_data;
      out_last <= s_axis_tlast ? 1'b0 : ch_end;
      out_user <= s_axis_tlast ? KIND_SUMMARY : KIND_CHAR;
    end
  end

  a_last_gives_summary: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> m_axis_tvalid && m_axis_tuser == KIND_SUMMARY)
    else $error("summary beat missing after final message byte");

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> phase == PH_HEADER && pos_cnt == 4'd0)
    else $error("parser not back at header after final byte");

  a_end_only_on_char: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_CHAR
      && m_axis_tdata[7:0] == CH_DOT)
    else $error("name end flagged on something other than a dot");

  a_label_count_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LABEL |-> label_left != 8'd0)
    else $error("label phase with no label bytes left");

endmodule
